### rtl/rcsp_pkg.sv
// Shared types and constants for the command stream parser.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package rcsp_pkg;

  localparam int DEF_COUNT_WIDTH  = 8;
  localparam int DEF_LENGTH_WIDTH = 30;

  localparam int MAX_ELEM_W = 8;
  localparam int MAX_LEN_W  = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ELEMENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 2'd1;

  localparam logic [MAX_ELEM_W-1:0] MAX_ELEM_RESET = 8'd255;
  localparam logic [MAX_LEN_W-1:0]  MAX_LEN_RESET  = 30'h2000_0000;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_ELEM_END  = 2'd1;
  localparam logic [1:0] KIND_EMPTY_CMD = 2'd2;
  localparam logic [1:0] KIND_ERROR     = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NO_STAR   = 2'd0;
  localparam logic [1:0] ERR_COUNT     = 2'd1;
  localparam logic [1:0] ERR_LENGTH    = 2'd2;
  localparam logic [1:0] ERR_MISMATCH  = 2'd3;

  // framing bytes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [8:0] {
    PH_STAR   = 9'b0_0000_0001,
    PH_CNT    = 9'b0_0000_0010,
    PH_CNT_LF = 9'b0_0000_0100,
    PH_DOLLAR = 9'b0_0000_1000,
    PH_LEN    = 9'b0_0001_0000,
    PH_LEN_LF = 9'b0_0010_0000,
    PH_PAY    = 9'b0_0100_0000,
    PH_PAY_CR = 9'b0_1000_0000,
    PH_PAY_LF = 9'b1_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] element_number;
    logic       command_done;
    logic [1:0] error_code;
  } result_t;

endpackage

`default_nettype wire

### rtl/rcsp_if.sv
// Valid/ready channel interfaces for the parser: byte stream, results, config writes.
// Depends on rcsp_pkg for field widths.
`default_nettype none

interface rcsp_byte_if import rcsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rcsp_result_if import rcsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] element_number;
  logic       command_done;
  logic [1:0] error_code;

  modport source (output valid, output kind, output data_byte, output element_number,
                  output command_done, output error_code, input ready);
  modport sink (input valid, input kind, input data_byte, input element_number,
                input command_done, input error_code, output ready);
endinterface

interface rcsp_cfg_if import rcsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/resp_command_stream_parser_top.sv
// Parser for a byte stream of "*count CRLF" / "$len CRLF payload CRLF" commands.
// Depends on rcsp_pkg and the channel interfaces in rcsp_if.sv.
`default_nettype none

// One byte is taken per cycle whenever the skid register is empty; each byte
// is decoded in the cycle it is accepted (one digit multiply-add and limit
// compare at most); any result goes to the output register, or to the skid
// word while that is stalled. A stalled output costs nothing until a second
// result has to wait, at which point stream.ready drops. Payload bytes come
// out tagged with their element number; the CRLF ending an element gives an
// element-end word that flags the last element of the command; a zero count
// gives an empty-command word. The first framing error gives one error word,
// after which bytes are accepted and dropped until reset. Config writes are
// always ready and take effect on the next byte.
module resp_command_stream_parser_top
  import rcsp_pkg::*;
#(
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
  parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  wire              clk,
  input  wire              rst,
  rcsp_byte_if.sink        stream,
  rcsp_result_if.source    result,
  rcsp_cfg_if.sink         cfg
);

  localparam int VW = (LENGTH_WIDTH + 4 > MAX_LEN_W) ? LENGTH_WIDTH + 4 : MAX_LEN_W;

  logic [MAX_ELEM_W-1:0]   max_elements;
  logic [MAX_LEN_W-1:0]    max_length;

  phase_t                  phase, phase_next;
  logic [LENGTH_WIDTH-1:0] number_accumulator, number_accumulator_next;
  logic [COUNT_WIDTH-1:0]  elements_remaining, elements_remaining_next;
  logic [COUNT_WIDTH-1:0]  current_element, current_element_next;
  logic [LENGTH_WIDTH-1:0] bytes_remaining, bytes_remaining_next;
  logic                    have_digit, have_digit_next;
  logic                    halted, halted_next;

  logic                    out_valid, skid_valid;
  result_t                 out_word, skid_word;

  logic                    take;
  logic [7:0]              b;
  logic                    is_digit;
  logic [VW-1:0]           acc_val;
  logic                    cnt_ok, len_ok;
  logic                    res_valid;
  result_t                 res;

  assign cfg.ready    = 1'b1;
  assign stream.ready = !skid_valid;
  assign take         = stream.valid && stream.ready;
  assign b            = stream.in_byte;

  // acc*10 + digit, wide enough to see overflow past either limit
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign acc_val  = (VW'(number_accumulator) << 3) + (VW'(number_accumulator) << 1)
                  + VW'(4'(b - CH_ZERO));
  assign cnt_ok   = is_digit && (acc_val <= VW'(max_elements))
                  && ((acc_val >> COUNT_WIDTH) == '0);
  assign len_ok   = is_digit && (acc_val <= VW'(max_length))
                  && ((acc_val >> LENGTH_WIDTH) == '0);

  always_comb begin
    phase_next              = phase;
    number_accumulator_next = number_accumulator;
    elements_remaining_next = elements_remaining;
    current_element_next    = current_element;
    bytes_remaining_next    = bytes_remaining;
    have_digit_next         = have_digit;
    halted_next             = halted;
    res_valid               = 1'b0;
    res.kind                = KIND_PAYLOAD;
    res.data_byte           = '0;
    res.element_number      = 8'(current_element);
    res.command_done        = 1'b0;
    res.error_code          = ERR_NO_STAR;

    if (!halted) begin
      case (phase)
        PH_STAR: begin
          if (b != CH_STAR) begin
            res_valid      = 1'b1;
            res.error_code = ERR_NO_STAR;
          end else begin
            number_accumulator_next = '0;
            have_digit_next         = 1'b0;
            current_element_next    = '0;
            phase_next              = PH_CNT;
          end
        end
        PH_CNT: begin
          if (b == CH_CR && have_digit) begin
            phase_next = PH_CNT_LF;
          end else if (cnt_ok) begin
            number_accumulator_next = acc_val[LENGTH_WIDTH-1:0];
            have_digit_next         = 1'b1;
          end else begin
            res_valid      = 1'b1;
            res.error_code = ERR_COUNT;
          end
        end
        PH_CNT_LF: begin
          if (b != CH_LF) begin
            res_valid      = 1'b1;
            res.error_code = ERR_COUNT;
          end else begin
            elements_remaining_next = number_accumulator[COUNT_WIDTH-1:0];
            current_element_next    = '0;
            if (number_accumulator == '0) begin
              phase_next         = PH_STAR;
              res_valid          = 1'b1;
              res.kind           = KIND_EMPTY_CMD;
              res.element_number = '0;
              res.command_done   = 1'b1;
            end else begin
              phase_next = PH_DOLLAR;
            end
          end
        end
        PH_DOLLAR: begin
          if (b != CH_DOLLAR) begin
            res_valid      = 1'b1;
            res.error_code = ERR_LENGTH;
          end else begin
            number_accumulator_next = '0;
            have_digit_next         = 1'b0;
            phase_next              = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b == CH_CR && have_digit) begin
            phase_next = PH_LEN_LF;
          end else if (len_ok) begin
            number_accumulator_next = acc_val[LENGTH_WIDTH-1:0];
            have_digit_next         = 1'b1;
          end else begin
            res_valid      = 1'b1;
            res.error_code = ERR_LENGTH;
          end
        end
        PH_LEN_LF: begin
          if (b != CH_LF) begin
            res_valid      = 1'b1;
            res.error_code = ERR_LENGTH;
          end else begin
            bytes_remaining_next = number_accumulator;
            phase_next = (number_accumulator == '0) ? PH_PAY_CR : PH_PAY;
          end
        end
        PH_PAY: begin
          bytes_remaining_next = bytes_remaining - 1'b1;
          if (bytes_remaining == LENGTH_WIDTH'(1)) begin
            phase_next = PH_PAY_CR;
          end
          res_valid     = 1'b1;
          res.data_byte = b;
        end
        PH_PAY_CR: begin
          if (b != CH_CR) begin
            res_valid      = 1'b1;
            res.error_code = ERR_MISMATCH;
          end else begin
            phase_next = PH_PAY_LF;
          end
        end
        PH_PAY_LF: begin
          if (b != CH_LF) begin
            res_valid      = 1'b1;
            res.error_code = ERR_MISMATCH;
          end else begin
            res_valid        = 1'b1;
            res.kind         = KIND_ELEM_END;
            res.command_done = (elements_remaining <= COUNT_WIDTH'(1));
            if (elements_remaining <= COUNT_WIDTH'(1)) begin
              elements_remaining_next = '0;
              current_element_next    = '0;
              phase_next              = PH_STAR;
            end else begin
              elements_remaining_next = elements_remaining - 1'b1;
              current_element_next    = current_element + 1'b1;
              phase_next              = PH_DOLLAR;
            end
          end
        end
        default: begin
          phase_next     = PH_STAR;
          res_valid      = 1'b1;
          res.error_code = ERR_NO_STAR;
        end
      endcase

      // every result except payload, element end and empty command is an error
      if (res_valid && !(phase == PH_PAY) && !(phase == PH_PAY_LF && b == CH_LF)
          && !(phase == PH_CNT_LF && b == CH_LF)) begin
        res.kind    = KIND_ERROR;
        halted_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_elements       <= MAX_ELEM_RESET;
      max_length         <= MAX_LEN_RESET;
      phase              <= PH_STAR;
      number_accumulator <= '0;
      elements_remaining <= '0;
      current_element    <= '0;
      bytes_remaining    <= '0;
      have_digit         <= 1'b0;
      halted             <= 1'b0;
    end else begin
      if (cfg.valid && cfg.index == REG_MAX_ELEMENTS) begin
        max_elements <= cfg.data[MAX_ELEM_W-1:0];
      end
      if (cfg.valid && cfg.index == REG_MAX_LENGTH) begin
        max_length <= cfg.data[MAX_LEN_W-1:0];
      end
      if (take) begin
        phase              <= phase_next;
        number_accumulator <= number_accumulator_next;
        elements_remaining <= elements_remaining_next;
        current_element    <= current_element_next;
        bytes_remaining    <= bytes_remaining_next;
        have_digit         <= have_digit_next;
        halted             <= halted_next;
      end
    end
  end

  // output register plus one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take && res_valid;
      end
    end else if (take && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_word <= skid_valid ? skid_word : res;
    end else if (take && res_valid) begin
      skid_word <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_word.kind;
  assign result.data_byte      = out_word.data_byte;
  assign result.element_number = out_word.element_number;
  assign result.command_done   = out_word.command_done;
  assign result.error_code     = out_word.error_code;

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halted cleared without reset");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid word held with empty output register");

  a_skid_blocks_input: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !stream.ready) else $error("byte accepted with full skid");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAY && !halted) |-> bytes_remaining != '0)
    else $error("payload phase with no bytes left");

  a_elements_left: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_DOLLAR || phase == PH_PAY_LF) && !halted) |-> elements_remaining != '0)
    else $error("element phase with no elements left");

endmodule

`default_nettype wire

### bench/rcsp_result_checker.sv
// Result checker for the command stream parser: predicts the result words of
// every accepted stream byte and compares them with the words the block emits.
// Depends on rcsp_pkg and the channel interfaces in rcsp_if.sv.

module rcsp_result_checker
  import rcsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  rcsp_byte_if   stream,
  rcsp_result_if result,
  rcsp_cfg_if    cfg,
  output int     fail_count,
  output int     pending_words
);

  localparam logic [63:0] COUNT_CAP  = (64'd1 << DEF_COUNT_WIDTH) - 1;
  localparam logic [63:0] LENGTH_CAP = (64'd1 << DEF_LENGTH_WIDTH) - 1;
  localparam logic [1:0]  NO_CODE    = 2'd0;

  logic [MAX_ELEM_W-1:0] lim_elems;
  logic [MAX_LEN_W-1:0]  lim_len;

  phase_t      ph;
  logic [29:0] acc;
  logic [7:0]  elems_left;
  logic [7:0]  elem_idx;
  logic [29:0] bytes_left;
  logic        halted;
  logic        got_digit;

  result_t expected_words[$];
  int      mismatches;

  function automatic result_t make_word(logic [1:0] kind, logic [7:0] data, logic done,
                                        logic [1:0] code);
    result_t w;
    w.kind           = kind;
    w.data_byte      = data;
    w.element_number = elem_idx;
    w.command_done   = done;
    w.error_code     = code;
    return w;
  endfunction

  task automatic expect_word(result_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic flag_error(logic [1:0] code);
    halted = 1'b1;
    expect_word(make_word(KIND_ERROR, 8'h00, 1'b0, code));
  endtask

  // decimal digit into the accumulator; fails on a non-digit or overflow of the limit
  function automatic logic take_digit(logic [7:0] b, logic [63:0] limit);
    logic [63:0] v;
    if (b < CH_ZERO || b > CH_NINE) return 1'b0;
    v = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
    if (v > limit) return 1'b0;
    acc       = v[29:0];
    got_digit = 1'b1;
    return 1'b1;
  endfunction

  task automatic parse_byte(logic [7:0] b);
    logic [63:0] cnt_lim;
    logic [63:0] len_lim;
    logic        last;
    cnt_lim = (64'(lim_elems) < COUNT_CAP) ? 64'(lim_elems) : COUNT_CAP;
    len_lim = (64'(lim_len) < LENGTH_CAP) ? 64'(lim_len) : LENGTH_CAP;
    if (!halted) begin
      case (ph)
        PH_STAR: begin
          if (b != CH_STAR) flag_error(ERR_NO_STAR);
          else begin
            acc       = '0;
            got_digit = 1'b0;
            elem_idx  = '0;
            ph        = PH_CNT;
          end
        end
        PH_CNT: begin
          if (b == CH_CR && got_digit) ph = PH_CNT_LF;
          else if (!take_digit(b, cnt_lim)) flag_error(ERR_COUNT);
        end
        PH_CNT_LF: begin
          if (b != CH_LF) flag_error(ERR_COUNT);
          else begin
            elems_left = acc[7:0];
            elem_idx   = '0;
            if (elems_left == 0) begin
              ph = PH_STAR;
              expect_word(make_word(KIND_EMPTY_CMD, 8'h00, 1'b1, NO_CODE));
            end else begin
              ph = PH_DOLLAR;
            end
          end
        end
        PH_DOLLAR: begin
          if (b != CH_DOLLAR) flag_error(ERR_LENGTH);
          else begin
            acc       = '0;
            got_digit = 1'b0;
            ph        = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b == CH_CR && got_digit) ph = PH_LEN_LF;
          else if (!take_digit(b, len_lim)) flag_error(ERR_LENGTH);
        end
        PH_LEN_LF: begin
          if (b != CH_LF) flag_error(ERR_LENGTH);
          else begin
            bytes_left = acc;
            ph         = (acc == 0) ? PH_PAY_CR : PH_PAY;
          end
        end
        PH_PAY: begin
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == 0) ph = PH_PAY_CR;
          expect_word(make_word(KIND_PAYLOAD, b, 1'b0, NO_CODE));
        end
        PH_PAY_CR: begin
          if (b != CH_CR) flag_error(ERR_MISMATCH);
          else ph = PH_PAY_LF;
        end
        PH_PAY_LF: begin
          if (b != CH_LF) flag_error(ERR_MISMATCH);
          else begin
            last = (elems_left <= 1);
            expect_word(make_word(KIND_ELEM_END, 8'h00, last, NO_CODE));
            if (last) begin
              elems_left = '0;
              elem_idx   = '0;
              ph         = PH_STAR;
            end else begin
              elems_left = elems_left - 1'b1;
              elem_idx   = elem_idx + 1'b1;
              ph         = PH_DOLLAR;
            end
          end
        end
        default: begin
          ph = PH_STAR;
          flag_error(ERR_NO_STAR);
        end
      endcase
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      lim_elems  = MAX_ELEM_RESET;
      lim_len    = MAX_LEN_RESET;
      ph         = PH_STAR;
      acc        = '0;
      elems_left = '0;
      elem_idx   = '0;
      bytes_left = '0;
      halted     = 1'b0;
      got_digit  = 1'b0;
      mismatches = 0;
      expected_words.delete();
    end else begin
      // words out first, so a stray word never pairs with a same-edge prediction
      if (result.valid && result.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: kind %0d, data %0d", result.kind, result.data_byte);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", 8'(want.kind), 8'(result.kind));
          check_field("data_byte", want.data_byte, result.data_byte);
          check_field("element_number", want.element_number, result.element_number);
          check_field("command_done", 8'(want.command_done), 8'(result.command_done));
          check_field("error_code", 8'(want.error_code), 8'(result.error_code));
        end
      end
      if (stream.valid && stream.ready) parse_byte(stream.in_byte);
      // a write on the same edge as a byte applies from the next byte on
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_MAX_ELEMENTS: lim_elems = cfg.data[MAX_ELEM_W-1:0];
          REG_MAX_LENGTH:   lim_len   = cfg.data[MAX_LEN_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count    <= mismatches;
    pending_words <= expected_words.size();
  end

endmodule

### bench/tb_resp_command_stream_parser_top.sv
// Testbench top for the command stream parser: drives well-formed commands with
// random content under several register settings, then one framing error.
// Depends on rcsp_pkg, rcsp_if.sv, the parser top and rcsp_result_checker.

module tb_resp_command_stream_parser_top;
  import rcsp_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_COUNT  = 30;

  logic clk = 1'b0;
  logic rst;

  rcsp_byte_if   stream_ch ();
  rcsp_result_if result_ch ();
  rcsp_cfg_if    cfg_ch ();

  int fail_count;
  int pending_words;
  int quiet_cycles = 0;
  int bytes_sent   = 0;
  int src_idle     = 0;
  int snk_idle     = 10;
  bit calm         = 1'b0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  logic [MAX_ELEM_W-1:0] lim_elems_cfg = MAX_ELEM_RESET;
  logic [MAX_LEN_W-1:0]  lim_len_cfg   = MAX_LEN_RESET;
  logic [7:0]            cmd_bytes[$];

  always #6 clk = ~clk;

  resp_command_stream_parser_top DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rcsp_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .stream        (stream_ch),
    .result        (result_ch),
    .cfg           (cfg_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < snk_idle) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: snk_idle = 0;
          1: snk_idle = 15;
          default: snk_idle = 40;
        endcase
      end
    end
  end

  function automatic int lead_zeros();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  // payload bytes lean toward framing characters
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0: return CH_DOLLAR;
      1: return CH_CR;
      2: return CH_LF;
      3: return CH_STAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random byte outside lo..hi and not equal to also
  function automatic logic [7:0] pick_other(logic [7:0] lo, logic [7:0] hi, logic [7:0] also);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while ((b >= lo && b <= hi) || b == also);
    return b;
  endfunction

  task automatic add_byte(logic [7:0] b);
    cmd_bytes.insert(cmd_bytes.size(), b);
  endtask

  task automatic push_number(longint unsigned v, int zeros);
    logic [7:0] digits[$];
    repeat (zeros) add_byte(CH_ZERO);
    do begin
      digits.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) add_byte(digits[i]);
  endtask

  task automatic push_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic queue_command(int count, int len_top);
    int len;
    add_byte(CH_STAR);
    push_number(count, lead_zeros());
    push_crlf();
    for (int i = 0; i < count; i++) begin
      len = $urandom_range(0, len_top);
      add_byte(CH_DOLLAR);
      push_number(len, lead_zeros());
      push_crlf();
      repeat (len) add_byte(payload_byte());
      push_crlf();
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    stream_ch.valid   <= 1'b1;
    stream_ch.in_byte <= b;
    do @(posedge clk); while (!stream_ch.ready);
    bytes_sent++;
    if (!calm && $urandom_range(0, 99) < src_idle) begin
      stream_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_queued();
    while (cmd_bytes.size() > 0) send_byte(cmd_bytes.pop_front());
  endtask

  task automatic random_commands(int budget);
    int stop_at;
    int ctop;
    int count;
    int len_top;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 2))
        0: src_idle = 0;
        1: src_idle = 10;
        default: src_idle = 35;
      endcase
      ctop = (lim_elems_cfg < 6) ? int'(lim_elems_cfg) : 6;
      if ($urandom_range(0, 9) == 0) ctop = (lim_elems_cfg < 20) ? int'(lim_elems_cfg) : 20;
      if (lim_elems_cfg <= 20 && $urandom_range(0, 7) == 0) count = int'(lim_elems_cfg);
      else count = $urandom_range(0, ctop);
      if (lim_len_cfg < 12) len_top = int'(lim_len_cfg);
      else if ($urandom_range(0, 9) == 0) len_top = (lim_len_cfg < 48) ? int'(lim_len_cfg) : 48;
      else len_top = 12;
      queue_command(count, len_top);
      send_queued();
      if (!hold_done && bytes_sent >= 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
    end
  endtask

  // stop the stream and wait until every predicted word is out
  task automatic settle();
    stream_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MAX_ELEMENTS: lim_elems_cfg = value[MAX_ELEM_W-1:0];
      REG_MAX_LENGTH:   lim_len_cfg   = value[MAX_LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one framing error of a random sort; the block halts after it
  task automatic queue_broken_command();
    case ($urandom_range(0, 9))
      0: add_byte(pick_other(CH_STAR, CH_STAR, CH_STAR));
      1: begin  // non-digit in the count
        add_byte(CH_STAR);
        push_number($urandom_range(1, 9), 0);
        add_byte(pick_other(CH_ZERO, CH_NINE, CH_CR));
      end
      2: begin  // CR before any count digit
        add_byte(CH_STAR);
        add_byte(CH_CR);
      end
      3: begin  // count above the limit
        add_byte(CH_STAR);
        push_number(lim_elems_cfg + 1, 0);
      end
      4: begin  // count CR without LF
        add_byte(CH_STAR);
        push_number(1, 0);
        add_byte(CH_CR);
        add_byte(pick_other(CH_LF, CH_LF, CH_LF));
      end
      5: begin  // element without its marker
        add_byte(CH_STAR);
        push_number(1, 0);
        push_crlf();
        add_byte(pick_other(CH_DOLLAR, CH_DOLLAR, CH_DOLLAR));
      end
      6: begin  // length above the limit
        add_byte(CH_STAR);
        push_number(1, 0);
        push_crlf();
        add_byte(CH_DOLLAR);
        push_number(lim_len_cfg + 1, 0);
      end
      7: begin  // length CR with no digits, or CR without LF
        add_byte(CH_STAR);
        push_number(1, 0);
        push_crlf();
        add_byte(CH_DOLLAR);
        if ($urandom_range(0, 1) == 0) begin
          add_byte(CH_CR);
        end else begin
          push_number(3, 0);
          add_byte(CH_CR);
          add_byte(pick_other(CH_LF, CH_LF, CH_LF));
        end
      end
      8: begin  // payload longer than declared
        add_byte(CH_STAR);
        push_number(1, 0);
        push_crlf();
        add_byte(CH_DOLLAR);
        push_number(2, 0);
        push_crlf();
        repeat (2) add_byte(payload_byte());
        add_byte(pick_other(CH_CR, CH_CR, CH_CR));
      end
      default: begin  // second element ends in CR without LF
        add_byte(CH_STAR);
        push_number(2, 0);
        push_crlf();
        add_byte(CH_DOLLAR);
        push_number(0, 0);
        push_crlf();
        push_crlf();
        add_byte(CH_DOLLAR);
        push_number(1, 0);
        push_crlf();
        add_byte(payload_byte());
        add_byte(CH_CR);
        add_byte(pick_other(CH_LF, CH_LF, CH_LF));
      end
    endcase
  endtask

  initial begin
    rst               <= 1'b1;
    stream_ch.valid   <= 1'b0;
    stream_ch.in_byte <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty command with a leading zero, zero-length element,
    // payload with extreme and framing byte values
    add_byte(CH_STAR);
    push_number(0, 1);
    push_crlf();
    add_byte(CH_STAR);
    push_number(2, 0);
    push_crlf();
    add_byte(CH_DOLLAR);
    push_number(0, 0);
    push_crlf();
    push_crlf();
    add_byte(CH_DOLLAR);
    push_number(4, 1);
    push_crlf();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_CR);
    add_byte(CH_LF);
    push_crlf();
    send_queued();

    random_commands(220);

    // both limits at zero: only empty commands pass
    settle();
    write_reg(REG_MAX_ELEMENTS, '0);
    write_reg(REG_MAX_LENGTH, '0);
    random_commands(40);

    // long command of zero-length elements
    settle();
    write_reg(REG_MAX_ELEMENTS, 30'(MAX_ELEM_RESET));
    queue_command(LONG_COUNT, 0);
    send_queued();
    random_commands(60);

    settle();
    write_reg(REG_MAX_ELEMENTS, 30'd1);
    write_reg(REG_MAX_LENGTH, MAX_LEN_RESET);
    random_commands(180);

    settle();
    write_reg(REG_MAX_ELEMENTS, 30'($urandom_range(2, 9)));
    write_reg(REG_MAX_LENGTH, 30'($urandom_range(1, 30)));
    random_commands(220);

    settle();
    write_reg(REG_MAX_ELEMENTS, 30'(MAX_ELEM_RESET));
    write_reg(REG_MAX_LENGTH, MAX_LEN_RESET);
    random_commands(180);
    calm = 1'b1;
    random_commands(140);

    // framing error, then bytes that the halted block must drop
    queue_broken_command();
    repeat (16) add_byte(8'($urandom_range(0, 255)));
    send_queued();

    stream_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_words != 0) $error("%0d expected words never arrived", pending_words);
    if (fail_count == 0 && pending_words == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
